### rtl/srbp_pkg.sv
// package: item types, register codes, sizes and the sine and cosine tables
package srbp_pkg;

    localparam int SPRITE_PIXELS = 4096;
    localparam int MAX_SIDE      = 64;
    localparam int ANGLE_STEPS   = 360;

    localparam int SPRITE_AW = $clog2(SPRITE_PIXELS);
    localparam int SIDE_W    = $clog2(MAX_SIDE) + 1;
    localparam int COORD_W   = SIDE_W + 4;
    localparam int ANGLE_W   = 9;
    localparam int TRIG_W    = 18;
    localparam int CFG_DW    = 9;
    localparam int CFG_IW    = 3;

    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
    localparam logic [63:0] PI_STEP = PI_Q62 / 64'd180;

    typedef enum logic [CFG_IW-1:0] {
        CFG_SPRITE_WIDTH,
        CFG_SPRITE_HEIGHT,
        CFG_ROTATE_ENABLE,
        CFG_BLEND_ENABLE,
        CFG_ANGLE_DEGREES
    } t_cfg_reg;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_DRAW = 1'b1
    } t_action;

    typedef struct packed {
        logic               action;
        logic [11:0]        sprite_index;
        logic [31:0]        sprite_pixel;
        logic signed [7:0]  offset_x;
        logic signed [7:0]  offset_y;
        logic [31:0]        dest_pixel;
    } t_in_item;

    typedef struct packed {
        logic [31:0] new_pixel;
        logic        write_enable;
    } t_out_item;

    typedef logic [ANGLE_STEPS-1:0][TRIG_W-1:0] t_trig_table;

    // (a*b) >> 62 for q62 values below 2
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, lo, m1, m2, hi, t, lo64, hi64;
        al   = {32'd0, a[31:0]};
        ah   = {32'd0, a[63:32]};
        bl   = {32'd0, b[31:0]};
        bh   = {32'd0, b[63:32]};
        lo   = al * bl;
        m1   = ah * bl;
        m2   = al * bh;
        hi   = ah * bh;
        t    = (lo >> 32) + {32'd0, m1[31:0]} + {32'd0, m2[31:0]};
        lo64 = {t[31:0], lo[31:0]};
        hi64 = hi + (m1 >> 32) + (m2 >> 32) + (t >> 32);
        return (hi64 << 2) | (lo64 >> 62);
    endfunction

    // unsigned quotient by shift and subtract
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        int          b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // truncated sine in q16 for 0 to 90 degrees
    function automatic logic [TRIG_W-1:0] quarter_sine(input int d);
        logic [63:0] x, x2, term, sum, den;
        int          k;
        x    = 64'(d) * PI_STEP;
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (k = 1; k < 30; k++) begin
            if (term != 64'd0) begin
                den  = 64'((2 * k) * (2 * k + 1));
                term = div_u64(mul_q62(term, x2), den);
                if ((k % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        if (d == 0) begin
            return '0;
        end else if (d == 30) begin
            return TRIG_W'(32768);
        end else if (d >= 90) begin
            return TRIG_W'(65536);
        end
        return TRIG_W'(sum >> 46);
    endfunction

    function automatic logic [TRIG_W-1:0] full_sine(input int i);
        if (i <= 90) begin
            return quarter_sine(i);
        end else if (i <= 180) begin
            return quarter_sine(180 - i);
        end else if (i <= 270) begin
            return TRIG_W'(0) - quarter_sine(i - 180);
        end
        return TRIG_W'(0) - quarter_sine(360 - i);
    endfunction

    function automatic t_trig_table build_trig(input logic cosine);
        t_trig_table tbl;
        int          i;
        for (i = 0; i < ANGLE_STEPS; i++) begin
            if (cosine) begin
                tbl[i] = full_sine((i < 270) ? i + 90 : i - 270);
            end else begin
                tbl[i] = full_sine(i);
            end
        end
        return tbl;
    endfunction

    localparam t_trig_table SINE_ROM   = build_trig(1'b0);
    localparam t_trig_table COSINE_ROM = build_trig(1'b1);

endpackage

### rtl/srbp_ram.sv
// generic simple dual port ram with registered read
module srbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sprite_rotate_blend_pixel.sv
// sprite pixel shader: rotation lookup, sprite store read and alpha blend
//
//  channel | direction | handshake                 | payload
//  in      | request   | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | result    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  cfg     | write     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one request per cycle while the skid stage is empty; a result reaches o_out_valid
// after its request passes the input reg, rotate multiply, sum and bounds, store read,
// blend multiply and output reg
// synchronous active low reset clears valids and config; the store is not cleared
// a stalled output fills a one entry skid stage, then the whole pipe holds
module sprite_rotate_blend_pixel
    import srbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    logic                     r_rotate;
    logic                     r_blend;
    logic [SIDE_W-1:0]        r_width;
    logic [SIDE_W-1:0]        r_height;
    logic [ANGLE_W-1:0]       r_angle;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;

    logic ce;

    // stage 1: request
    logic     r_s1_valid;
    t_in_item r_s1;

    // stage 2: rotate products
    logic              r_s2_valid;
    logic              r_s2_draw;
    logic [11:0]       r_s2_index;
    logic [31:0]       r_s2_pixel;
    logic [31:0]       r_s2_dest;
    logic signed [7:0] r_s2_ox;
    logic signed [7:0] r_s2_oy;
    logic signed [25:0] r_s2_xc, r_s2_ys, r_s2_yc, r_s2_xs;
    logic signed [25:0] n_xc, n_ys, n_yc, n_xs;

    // stage 3: source coordinates
    logic              r_s3_valid;
    logic              r_s3_draw;
    logic [11:0]       r_s3_index;
    logic [31:0]       r_s3_pixel;
    logic [31:0]       r_s3_dest;
    logic              r_s3_inb;
    logic [SIDE_W-2:0] r_s3_rx;
    logic [SIDE_W-2:0] r_s3_ry;
    logic signed [26:0]        n_rx_full, n_ry_full, w_bias, h_bias;
    logic signed [COORD_W-1:0] n_rx, n_ry;
    logic                      n_inb;

    // stage 4: store read
    logic        r_s4_valid;
    logic        r_s4_draw;
    logic        r_s4_inb;
    logic [31:0] r_s4_dest;
    logic [12:0] n_addr_full;
    logic [31:0] rd_pixel;
    logic        ram_we;

    // stage 5: blend products
    logic               r_s5_valid;
    logic               r_s5_we;
    logic               r_s5_blend;
    logic [31:0]        r_s5_pixel;
    logic [31:0]        r_s5_dest;
    logic signed [34:0] r_s5_prb;
    logic signed [26:0] r_s5_pg;
    logic [8:0]         n_sa;
    logic signed [24:0] n_drb_diff;
    logic signed [16:0] n_dg_diff;
    logic signed [34:0] n_prb;
    logic signed [26:0] n_pg;
    logic               n_we;

    // result and output side
    logic signed [34:0] rb_sum;
    logic signed [26:0] g_sum;
    t_out_item          n_result;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               r_skid_valid;
    t_out_item          r_skid;
    logic               pipe_out;

    assign o_cfg_ready = 1'b1;
    assign ce          = !r_skid_valid;
    assign o_in_ready  = ce;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIDE_W'(1);
            r_height <= SIDE_W'(1);
            r_rotate <= 1'b0;
            r_blend  <= 1'b0;
            r_angle  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPRITE_WIDTH: begin
                    r_width <= (i_cfg_data[SIDE_W-1:0] > SIDE_W'(MAX_SIDE))
                             ? SIDE_W'(MAX_SIDE) : i_cfg_data[SIDE_W-1:0];
                end
                CFG_SPRITE_HEIGHT: begin
                    r_height <= (i_cfg_data[SIDE_W-1:0] > SIDE_W'(MAX_SIDE))
                              ? SIDE_W'(MAX_SIDE) : i_cfg_data[SIDE_W-1:0];
                end
                CFG_ROTATE_ENABLE: begin
                    r_rotate <= i_cfg_data[0];
                end
                CFG_BLEND_ENABLE: begin
                    r_blend <= i_cfg_data[0];
                end
                CFG_ANGLE_DEGREES: begin
                    r_angle <= (i_cfg_data >= ANGLE_W'(ANGLE_STEPS))
                             ? i_cfg_data - ANGLE_W'(ANGLE_STEPS) : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sin <= SINE_ROM[r_angle];
        r_cos <= COSINE_ROM[r_angle];
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ce) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s1 <= i_in_data;
        end
    end

    // stage 2
    assign n_xc = 26'(r_s1.offset_x) * 26'(r_cos);
    assign n_ys = 26'(r_s1.offset_y) * 26'(r_sin);
    assign n_yc = 26'(r_s1.offset_y) * 26'(r_cos);
    assign n_xs = 26'(r_s1.offset_x) * 26'(r_sin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (ce) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s2_draw  <= (r_s1.action == ACT_DRAW);
            r_s2_index <= r_s1.sprite_index;
            r_s2_pixel <= r_s1.sprite_pixel;
            r_s2_dest  <= r_s1.dest_pixel;
            r_s2_ox    <= r_s1.offset_x;
            r_s2_oy    <= r_s1.offset_y;
            r_s2_xc    <= n_xc;
            r_s2_ys    <= n_ys;
            r_s2_yc    <= n_yc;
            r_s2_xs    <= n_xs;
        end
    end

    // stage 3
    assign w_bias    = {{(27 - SIDE_W - 15){1'b0}}, r_width, 15'd0};
    assign h_bias    = {{(27 - SIDE_W - 15){1'b0}}, r_height, 15'd0};
    assign n_rx_full = 27'(r_s2_xc) + 27'(r_s2_ys) + w_bias;
    assign n_ry_full = 27'(r_s2_yc) - 27'(r_s2_xs) + h_bias;

    always_comb begin
        if (r_rotate) begin
            n_rx = n_rx_full[16 +: COORD_W];
            n_ry = n_ry_full[16 +: COORD_W];
        end else begin
            n_rx = COORD_W'(r_s2_ox);
            n_ry = COORD_W'(r_s2_oy);
        end
    end

    assign n_inb = !n_rx[COORD_W-1] && !n_ry[COORD_W-1]
                && (n_rx[COORD_W-2:0] < (COORD_W-1)'(r_width))
                && (n_ry[COORD_W-2:0] < (COORD_W-1)'(r_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (ce) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s3_draw  <= r_s2_draw;
            r_s3_index <= r_s2_index;
            r_s3_pixel <= r_s2_pixel;
            r_s3_dest  <= r_s2_dest;
            r_s3_inb   <= n_inb;
            r_s3_rx    <= n_rx[SIDE_W-2:0];
            r_s3_ry    <= n_ry[SIDE_W-2:0];
        end
    end

    // stage 4
    assign n_addr_full = 13'(r_s3_rx) + 13'(r_width) * 13'(r_s3_ry);
    assign ram_we      = ce && r_s3_valid && !r_s3_draw;

    srbp_ram #(
        .WIDTH (32),
        .DEPTH (SPRITE_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s3_index[SPRITE_AW-1:0]),
        .i_wdata (r_s3_pixel),
        .i_re    (ce),
        .i_raddr (n_addr_full[SPRITE_AW-1:0]),
        .o_rdata (rd_pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (ce) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s4_draw <= r_s3_draw;
            r_s4_inb  <= r_s3_inb;
            r_s4_dest <= r_s3_dest;
        end
    end

    // stage 5
    assign n_sa       = {1'b0, rd_pixel[31:24]} + 9'(rd_pixel[31:24] == 8'hFF);
    assign n_drb_diff = $signed({1'b0, rd_pixel[23:0] & 24'hFF00FF})
                      - $signed({1'b0, r_s4_dest[23:0] & 24'hFF00FF});
    assign n_dg_diff  = $signed({1'b0, rd_pixel[15:0] & 16'hFF00})
                      - $signed({1'b0, r_s4_dest[15:0] & 16'hFF00});
    assign n_prb      = 35'(n_drb_diff) * 35'($signed({1'b0, n_sa}));
    assign n_pg       = 27'(n_dg_diff) * 27'($signed({1'b0, n_sa}));
    assign n_we       = r_s4_draw && r_s4_inb && (rd_pixel[23:0] != 24'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (ce) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s5_we    <= n_we;
            r_s5_blend <= r_blend;
            r_s5_pixel <= rd_pixel;
            r_s5_dest  <= r_s4_dest;
            r_s5_prb   <= n_prb;
            r_s5_pg    <= n_pg;
        end
    end

    // result
    assign rb_sum = (r_s5_prb >>> 8) + 35'({11'd0, r_s5_dest[23:0] & 24'hFF00FF});
    assign g_sum  = (r_s5_pg >>> 8) + 27'({11'd0, r_s5_dest[15:0] & 16'hFF00});

    always_comb begin
        n_result.write_enable = r_s5_we;
        if (!r_s5_we) begin
            n_result.new_pixel = r_s5_dest;
        end else if (r_s5_blend) begin
            n_result.new_pixel = {8'd0, (rb_sum[23:0] & 24'hFF00FF)
                                      | {8'd0, g_sum[15:0] & 16'hFF00}};
        end else begin
            n_result.new_pixel = r_s5_pixel;
        end
    end

    // output register and skid stage
    assign pipe_out = ce && r_s5_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= pipe_out;
            end
        end else if (pipe_out) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (pipe_out) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
